### hw/rtl/timed_event_queue_scheduler_top_defines.svh
// Assertion macros for the scheduler engine RTL.
// Included by teqs_engine, which carries concurrent checks; needs nothing else.
`ifndef TIMED_EVENT_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define TIMED_EVENT_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TEQS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the edge that follows a cycle held in reset.
`define TEQS_ASSERT_AFTER_RESET(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

### hw/rtl/teqs_pkg.sv
// Types and constants of the timed event queue scheduler.
// No dependencies; imported by teqs_engine and the top level.
`default_nettype none

package teqs_pkg;

    localparam int TIME_W = 32;
    localparam int TASK_W = 8;
    localparam int OCC_W  = 6;
    localparam int PER_W  = 8;

    // Request codes carried on the slave tuser
    typedef enum logic [1:0] {
        REQ_SCHED  = 2'd0,
        REQ_STEP   = 2'd1,
        REQ_REBASE = 2'd2
    } t_req;

    // Result codes carried on the master tuser
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CPU  = 2'd1,
        KIND_TASK = 2'd2,
        KIND_FULL = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic CFG_CPU_ENABLE = 1'b0;
    localparam logic CFG_CPU_PERIOD = 1'b1;

    typedef struct packed {
        t_req               req_type;
        logic [TASK_W-1:0]  task_id;
        logic [TIME_W-1:0]  delay;
    } t_req_beat;

    typedef struct packed {
        t_kind              kind;
        logic [TASK_W-1:0]  out_task;
        logic [TIME_W-1:0]  now;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    typedef struct packed {
        logic               cpu_enable;
        logic [PER_W-1:0]   cpu_period;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/teqs_engine.sv
// Scheduler engine: sorted task queue in a ring memory, time keeping, request sequencer.
// Depends on teqs_pkg and the assertion macro header.
`default_nettype none
`include "timed_event_queue_scheduler_top_defines.svh"

module teqs_engine #(
    parameter int DEPTH   = 32,
    parameter int ID_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire teqs_pkg::t_req_beat i_req,
    input  wire teqs_pkg::t_cfg     i_cfg,
    output logic                    o_ready,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output teqs_pkg::t_result       o_res
);
    import teqs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = TIME_W + ID_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP,
        ST_REB,
        ST_DONE
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic [TIME_W-1:0]      r_gt;
    logic [TIME_W-1:0]      r_cpu_next;
    logic [AW-1:0]          r_addr;
    logic [CW-1:0]          r_k;
    logic [TIME_W-1:0]      r_new_due;
    logic [TIME_W-1:0]      r_carry_due;
    logic [ID_BITS-1:0]     r_carry_id;
    logic                   r_found;
    t_kind                  r_res_kind;
    logic [ID_BITS-1:0]     r_res_task;

    // Queue store: {due time, task id} per entry, ring addressed from r_head
    logic [WW-1:0]          r_mem [DEPTH];
    logic [WW-1:0]          r_rd_q;

    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WW-1:0]          wr_data;
    logic [AW-1:0]          addr_inc;
    logic [AW-1:0]          head_inc;
    logic [TIME_W-1:0]      rd_due;
    logic [ID_BITS-1:0]     rd_id;
    logic                   scan_take;
    logic                   step_hit;
    logic                   reb_last;
    logic [TIME_W-1:0]      slot_time;
    logic [TIME_W-1:0]      new_due;

    // Decode read data and ring increments
    always_comb begin
        rd_due    = r_rd_q[WW-1:ID_BITS];
        rd_id     = r_rd_q[ID_BITS-1:0];
        addr_inc  = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
        head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        scan_take = r_found || (rd_due > r_new_due);
        step_hit  = (r_count != '0) && (rd_due <= r_gt);
        reb_last  = (r_k == r_count - 1'b1);
        slot_time = r_gt + TIME_W'(i_cfg.cpu_period);
        new_due   = r_gt + i_req.delay;
    end

    // Drive the memory ports: read ahead one entry, write the entry in hand
    always_comb begin
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = {r_carry_due, r_carry_id};
        case (r_state)
            ST_SCAN: begin
                rd_addr = addr_inc;
                wr_en   = (r_k == r_count) || scan_take;
            end
            ST_REB: begin
                rd_addr = addr_inc;
                wr_en   = 1'b1;
                wr_data = {rd_due - r_gt, rd_id};
            end
            default: begin
                rd_addr = r_head;
            end
        endcase
    end

    // Synchronous memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_q <= r_mem[rd_addr];
    end

    // Request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_gt       <= '0;
            r_cpu_next <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_res_kind  <= KIND_NONE;
                        r_res_task  <= '0;
                        r_addr      <= r_head;
                        r_k         <= '0;
                        r_found     <= 1'b0;
                        r_new_due   <= new_due;
                        r_carry_due <= new_due;
                        r_carry_id  <= ID_BITS'(i_req.task_id);
                        case (i_req.req_type)
                            REQ_SCHED: begin
                                if (r_count == CW'(DEPTH)) begin
                                    r_res_kind <= KIND_FULL;
                                    r_state    <= ST_DONE;
                                end else begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            REQ_STEP: begin
                                r_state <= ST_STEP;
                            end
                            REQ_REBASE: begin
                                if (r_count == '0) begin
                                    r_cpu_next <= (r_gt < r_cpu_next) ?
                                                  r_cpu_next - r_gt : '0;
                                    r_gt       <= '0;
                                    r_state    <= ST_DONE;
                                end else begin
                                    r_state <= ST_REB;
                                end
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                // Walk from the head; from the insertion point on, carry each entry one down
                ST_SCAN: begin
                    if (r_k == r_count) begin
                        r_count <= r_count + 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        if (scan_take) begin
                            r_carry_due <= rd_due;
                            r_carry_id  <= rd_id;
                            r_found     <= 1'b1;
                        end
                        r_k    <= r_k + 1'b1;
                        r_addr <= addr_inc;
                    end
                end
                // Dispatch the head task, else advance CPU slots; CPU off sets time to all ones
                ST_STEP: begin
                    if (step_hit) begin
                        r_gt       <= rd_due;
                        r_res_task <= rd_id;
                        r_res_kind <= KIND_TASK;
                        r_head     <= head_inc;
                        r_count    <= r_count - 1'b1;
                    end else if (i_cfg.cpu_enable) begin
                        if (r_gt >= r_cpu_next) begin
                            r_res_kind <= KIND_CPU;
                            r_cpu_next <= slot_time;
                            r_gt       <= slot_time;
                        end else begin
                            r_gt <= r_cpu_next;
                        end
                    end else begin
                        r_gt <= '1;
                    end
                    r_state <= ST_DONE;
                end
                // Shift every stored due time down by the current time
                ST_REB: begin
                    r_k    <= r_k + 1'b1;
                    r_addr <= addr_inc;
                    if (reb_last) begin
                        r_cpu_next <= (r_gt < r_cpu_next) ? r_cpu_next - r_gt : '0;
                        r_gt       <= '0;
                        r_state    <= ST_DONE;
                    end
                end
                // Hold the result until the output register is free
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready            = (r_state == ST_IDLE);
    assign o_res_valid        = (r_state == ST_DONE);
    assign o_res.kind         = r_res_kind;
    assign o_res.out_task     = TASK_W'(r_res_task);
    assign o_res.now          = r_gt;
    assign o_res.occupancy    = OCC_W'(r_count);

    `TEQS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n,
        (r_state == ST_IDLE) && (r_count == '0), "engine not idle and empty after reset")
    `TEQS_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= CW'(DEPTH), "queue count beyond depth")
    `TEQS_ASSERT(a_start_idle, i_clk, i_rst_n,
        i_start |-> (r_state == ST_IDLE), "request started while busy")
    `TEQS_ASSERT(a_dispatch_pop, i_clk, i_rst_n,
        ((r_state == ST_STEP) && step_hit) |=> (r_count == $past(r_count) - 1'b1),
        "dispatch did not pop one entry")
    `TEQS_ASSERT(a_rebase_zero, i_clk, i_rst_n,
        ((r_state == ST_REB) && reb_last) |=> (r_gt == '0), "rebase left time non-zero")

endmodule

`default_nettype wire

### hw/rtl/timed_event_queue_scheduler_top.sv
// Timed event queue scheduler: stream wrapper, configuration registers, output register.
// Depends on teqs_pkg and teqs_engine.
//
// Usage: requests arrive as beats on the s_axis channel (tuser = request code,
// tdata = task id and delay). Every request gives exactly one result beat on
// m_axis (tuser = result kind, tdata = task id, time and queue occupancy).
// Configuration (CPU enable, CPU slot period) is written through the plain
// i_cfg_we / i_cfg_idx / i_cfg_wdata port while no request is in flight.
// Work per request, from accept to result in the output register: step,
//   unknown code or full-queue schedule: no walk of the memory; schedule:
//   walks every stored entry from the head, shifting entries one down from
//   the insertion point; rebase: walks every stored entry (none if empty).
// The queue memory has one write and one read port, which sets the one
// entry per cycle rate of schedule and rebase. One request is handled at a
// time; the next is taken as soon as the result sits in the output register.
// Reset (synchronous, active low) empties the queue and zeroes time and the
// CPU slot time; CPU enable returns to 1 and the period to 2. Queue memory
// contents are not cleared. When m_axis stalls, the result beat holds in the
// output register, one more request may complete into the engine, and the
// block then holds off s_axis until the output register drains.
`default_nettype none

module timed_event_queue_scheduler_top #(
    parameter int DEPTH   = 32,
    parameter int ID_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [7:0] task_id, [39:8] delay
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // Result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] out_task, [39:8] now, [45:40] occupancy
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata
);
    import teqs_pkg::*;

    t_cfg       r_cfg;
    t_req_beat  req;
    t_result    eng_res;
    t_result    r_out;
    logic       r_out_valid;
    logic       eng_ready;
    logic       eng_res_valid;
    logic       out_free;
    logic       start;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cpu_enable <= 1'b1;
            r_cfg.cpu_period <= PER_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CPU_ENABLE: r_cfg.cpu_enable <= i_cfg_wdata[0];
                CFG_CPU_PERIOD: r_cfg.cpu_period <= i_cfg_wdata[PER_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Unpack the request beat
    always_comb begin
        req.req_type = t_req'(s_axis_tuser);
        req.task_id  = s_axis_tdata[TASK_W-1:0];
        req.delay    = s_axis_tdata[TASK_W+TIME_W-1:TASK_W];
    end

    assign s_axis_tready = eng_ready;
    assign start         = s_axis_tvalid && eng_ready;
    assign out_free      = !r_out_valid || m_axis_tready;

    teqs_engine #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_cfg       (r_cfg),
        .o_ready     (eng_ready),
        .o_res_valid (eng_res_valid),
        .i_res_ready (out_free),
        .o_res       (eng_res)
    );

    // Output register: load a finished result, hold it while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.occupancy, r_out.now, r_out.out_task};

endmodule

`default_nettype wire
